// ===== rtl/core/gop_pkg.sv =====
// Shared types, constants and font table for the glyph to OLED page byte renderer.
`default_nettype none

package gop_pkg;

   localparam int          COL_W       = 7;
   localparam int          PAGE_W      = 3;
   localparam int          CODE_W      = 7;
   localparam int          BYTE_W      = 8;
   localparam int          FONT_COLS   = 6;
   localparam int          ROW_W       = FONT_COLS * BYTE_W;
   localparam int          QUEUE_DEPTH = 2;
   localparam int          PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int          QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [COL_W-1:0]  WRAP_COLUMN_RESET = 7'd122;
   localparam logic [CODE_W-1:0] FIRST_CODE        = 7'd32;
   localparam logic [BYTE_W-1:0] PAGE_CMD          = 8'hB0;
   localparam logic [BYTE_W-1:0] COL_HI_CMD        = 8'h10;
   localparam logic [3:0]        NIBBLE_MASK       = 4'hF;

   localparam int STEP_PAGE   = 0;
   localparam int STEP_COL_HI = 1;
   localparam int STEP_COL_LO = 2;
   localparam int STEP_DATA   = 3;

   typedef struct packed {
      logic [COL_W-1:0]  column;
      logic [PAGE_W-1:0] page;
      logic [CODE_W-1:0] char_code;
      logic              inverse;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              is_data;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic [COL_W-1:0]  column;
      logic [ROW_W-1:0]  glyph;
      logic              inverse;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   // Column 0 of a glyph sits in the top byte of its row.
   function automatic logic [BYTE_W-1:0] font_column(input logic [ROW_W-1:0] row,
                                                     input logic [2:0] sel);
      logic [BYTE_W-1:0] b;
      unique case (sel)
         3'd0:    b = row[47:40];
         3'd1:    b = row[39:32];
         3'd2:    b = row[31:24];
         3'd3:    b = row[23:16];
         3'd4:    b = row[15:8];
         3'd5:    b = row[7:0];
         default: b = '0;
      endcase
      return b;
   endfunction

   function automatic logic [ROW_W-1:0] font_row(input logic [CODE_W-1:0] idx);
      logic [ROW_W-1:0] r;
      unique case (idx)
         7'd0:    r = 48'h00_00_00_00_00_00;
         7'd1:    r = 48'h00_00_00_2f_00_00;
         7'd2:    r = 48'h00_00_07_00_07_00;
         7'd3:    r = 48'h00_14_7f_14_7f_14;
         7'd4:    r = 48'h00_24_2a_7f_2a_12;
         7'd5:    r = 48'h00_62_64_08_13_23;
         7'd6:    r = 48'h00_36_49_55_22_50;
         7'd7:    r = 48'h00_00_05_03_00_00;
         7'd8:    r = 48'h00_00_1c_22_41_00;
         7'd9:    r = 48'h00_00_41_22_1c_00;
         7'd10:   r = 48'h00_14_08_3E_08_14;
         7'd11:   r = 48'h00_08_08_3E_08_08;
         7'd12:   r = 48'h00_00_00_A0_60_00;
         7'd13:   r = 48'h00_08_08_08_08_08;
         7'd14:   r = 48'h00_00_60_60_00_00;
         7'd15:   r = 48'h00_20_10_08_04_02;
         7'd16:   r = 48'h00_3E_51_49_45_3E;
         7'd17:   r = 48'h00_00_42_7F_40_00;
         7'd18:   r = 48'h00_42_61_51_49_46;
         7'd19:   r = 48'h00_21_41_45_4B_31;
         7'd20:   r = 48'h00_18_14_12_7F_10;
         7'd21:   r = 48'h00_27_45_45_45_39;
         7'd22:   r = 48'h00_3C_4A_49_49_30;
         7'd23:   r = 48'h00_01_71_09_05_03;
         7'd24:   r = 48'h00_36_49_49_49_36;
         7'd25:   r = 48'h00_06_49_49_29_1E;
         7'd26:   r = 48'h00_00_36_36_00_00;
         7'd27:   r = 48'h00_00_56_36_00_00;
         7'd28:   r = 48'h00_08_14_22_41_00;
         7'd29:   r = 48'h00_14_14_14_14_14;
         7'd30:   r = 48'h00_00_41_22_14_08;
         7'd31:   r = 48'h00_02_01_51_09_06;
         7'd32:   r = 48'h00_32_49_59_51_3E;
         7'd33:   r = 48'h00_7C_12_11_12_7C;
         7'd34:   r = 48'h00_7F_49_49_49_36;
         7'd35:   r = 48'h00_3E_41_41_41_22;
         7'd36:   r = 48'h00_7F_41_41_22_1C;
         7'd37:   r = 48'h00_7F_49_49_49_41;
         7'd38:   r = 48'h00_7F_09_09_09_01;
         7'd39:   r = 48'h00_3E_41_49_49_7A;
         7'd40:   r = 48'h00_7F_08_08_08_7F;
         7'd41:   r = 48'h00_00_41_7F_41_00;
         7'd42:   r = 48'h00_20_40_41_3F_01;
         7'd43:   r = 48'h00_7F_08_14_22_41;
         7'd44:   r = 48'h00_7F_40_40_40_40;
         7'd45:   r = 48'h00_7F_02_0C_02_7F;
         7'd46:   r = 48'h00_7F_04_08_10_7F;
         7'd47:   r = 48'h00_3E_41_41_41_3E;
         7'd48:   r = 48'h00_7F_09_09_09_06;
         7'd49:   r = 48'h00_3E_41_51_21_5E;
         7'd50:   r = 48'h00_7F_09_19_29_46;
         7'd51:   r = 48'h00_46_49_49_49_31;
         7'd52:   r = 48'h00_01_01_7F_01_01;
         7'd53:   r = 48'h00_3F_40_40_40_3F;
         7'd54:   r = 48'h00_1F_20_40_20_1F;
         7'd55:   r = 48'h00_3F_40_38_40_3F;
         7'd56:   r = 48'h00_63_14_08_14_63;
         7'd57:   r = 48'h00_07_08_70_08_07;
         7'd58:   r = 48'h00_61_51_49_45_43;
         7'd59:   r = 48'h00_00_7F_41_41_00;
         7'd60:   r = 48'h00_02_04_08_10_20;
         7'd61:   r = 48'h00_00_41_41_7F_00;
         7'd62:   r = 48'h00_04_02_01_02_04;
         7'd63:   r = 48'h00_40_40_40_40_40;
         7'd64:   r = 48'h00_00_01_02_04_00;
         7'd65:   r = 48'h00_20_54_54_54_78;
         7'd66:   r = 48'h00_7F_48_44_44_38;
         7'd67:   r = 48'h00_38_44_44_44_20;
         7'd68:   r = 48'h00_38_44_44_48_7F;
         7'd69:   r = 48'h00_38_54_54_54_18;
         7'd70:   r = 48'h00_08_7E_09_01_02;
         7'd71:   r = 48'h00_18_A4_A4_A4_7C;
         7'd72:   r = 48'h00_7F_08_04_04_78;
         7'd73:   r = 48'h00_00_44_7D_40_00;
         7'd74:   r = 48'h00_40_80_84_7D_00;
         7'd75:   r = 48'h00_7F_10_28_44_00;
         7'd76:   r = 48'h00_00_41_7F_40_00;
         7'd77:   r = 48'h00_7C_04_18_04_78;
         7'd78:   r = 48'h00_7C_08_04_04_78;
         7'd79:   r = 48'h00_38_44_44_44_38;
         7'd80:   r = 48'h00_FC_24_24_24_18;
         7'd81:   r = 48'h00_18_24_24_18_FC;
         7'd82:   r = 48'h00_7C_08_04_04_08;
         7'd83:   r = 48'h00_48_54_54_54_20;
         7'd84:   r = 48'h00_04_3F_44_40_20;
         7'd85:   r = 48'h00_3C_40_40_20_7C;
         7'd86:   r = 48'h00_1C_20_40_20_1C;
         7'd87:   r = 48'h00_3C_40_30_40_3C;
         7'd88:   r = 48'h00_44_28_10_28_44;
         7'd89:   r = 48'h00_1C_A0_A0_A0_7C;
         7'd90:   r = 48'h00_44_64_54_4C_44;
         7'd91:   r = 48'h08_08_49_2A_14_08;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gop_front.sv =====
// Front end: takes requests, applies the page wrap and looks up the glyph row.
`default_nettype none

module gop_front #(
   parameter int GLYPH_COUNT = 96
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  gop_pkg::req_type          req,
   input  wire                       csr_wr_en,
   input  wire [gop_pkg::COL_W-1:0]  csr_wr_data,
   input  gop_pkg::queue_stat_type   q_stat,
   output logic                      push,
   output gop_pkg::desc_type         desc
);
   import gop_pkg::*;

   logic [COL_W-1:0]  wrap_column_ff;
   logic [COL_W-1:0]  wrap_column_in;
   logic [CODE_W-1:0] glyph_idx;
   logic              has_glyph;
   logic              wrap;

   always_comb begin
      wrap_column_in = csr_wr_en ? csr_wr_data : wrap_column_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_column_ff <= WRAP_COLUMN_RESET;
      end else begin
         wrap_column_ff <= wrap_column_in;
      end
   end

   assign req_stall = q_stat.full;
   assign push      = req_valid && !q_stat.full;
   assign wrap      = req.column > wrap_column_ff;
   assign glyph_idx = req.char_code - FIRST_CODE;
   assign has_glyph = (req.char_code >= FIRST_CODE) && (int'(glyph_idx) < GLYPH_COUNT);

   always_comb begin
      desc.page    = wrap ? req.page + PAGE_W'(1) : req.page;
      desc.column  = wrap ? '0 : req.column;
      desc.glyph   = has_glyph ? font_row(glyph_idx) : '0;
      desc.inverse = req.inverse;
   end

endmodule

`default_nettype wire

// ===== rtl/core/gop_queue.sv =====
// Short descriptor queue between the front end and the byte sequencer.
`default_nettype none

module gop_queue (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   input  gop_pkg::desc_type        push_desc,
   input  wire                      pop,
   output gop_pkg::desc_type        head,
   output gop_pkg::queue_stat_type  q_stat
);
   import gop_pkg::*;

   desc_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              do_push;
   logic              do_pop;

   assign q_stat.full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign q_stat.empty = count_ff == '0;
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/gop_back.sv =====
// Back end: steps through the command and glyph bytes into the output register.
`default_nettype none

module gop_back #(
   parameter int GLYPH_WIDTH = 6
) (
   input  wire                      clock,
   input  wire                      reset,
   input  gop_pkg::desc_type        head,
   input  gop_pkg::queue_stat_type  q_stat,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output gop_pkg::rsp_type         rsp
);
   import gop_pkg::*;

   localparam int            CW        = $clog2(GLYPH_WIDTH + 3);
   localparam logic [CW-1:0] LAST_STEP = CW'(GLYPH_WIDTH + 2);

   logic [CW-1:0]     step_ff;
   logic [CW-1:0]     step_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;
   logic              advance;
   logic              is_last;
   logic [CW:0]       data_col;
   logic              col_in_font;
   logic [BYTE_W-1:0] data_byte;

   assign advance     = !q_stat.empty && (!rsp_valid_ff || !rsp_stall);
   assign is_last     = step_ff == LAST_STEP;
   assign pop         = advance && is_last;
   assign data_col    = {1'b0, step_ff} - (CW + 1)'(STEP_DATA);
   assign col_in_font = (step_ff >= CW'(STEP_DATA)) && (data_col < (CW + 1)'(FONT_COLS));
   assign data_byte   = (col_in_font ? font_column(head.glyph, data_col[2:0]) : '0)
                        ^ {BYTE_W{head.inverse}};

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      step_in      = step_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         step_in      = is_last ? '0 : step_ff + CW'(1);
         rsp_in.last  = is_last;
         priority if (step_ff == CW'(STEP_PAGE)) begin
            rsp_in.out_byte = PAGE_CMD | BYTE_W'(head.page);
            rsp_in.is_data  = 1'b0;
         end else if (step_ff == CW'(STEP_COL_HI)) begin
            rsp_in.out_byte = COL_HI_CMD | BYTE_W'(head.column[COL_W-1:4]);
            rsp_in.is_data  = 1'b0;
         end else if (step_ff == CW'(STEP_COL_LO)) begin
            rsp_in.out_byte = BYTE_W'(head.column[3:0] & NIBBLE_MASK);
            rsp_in.is_data  = 1'b0;
         end else begin
            rsp_in.out_byte = data_byte;
            rsp_in.is_data  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/core/glyph_to_oled_page_bytes_core.sv =====
// Top level of the 6x8 font glyph renderer for page-addressed OLED controllers.
// Each request yields 3 + GLYPH_WIDTH bytes (9 by default): page select, column high
// nibble, column low nibble, then the glyph columns, one byte per cycle out of the
// back-end byte sequencer while the queue is not empty and rsp_stall is low. A request
// is taken in the cycle it arrives while the two-entry queue has room; its first byte
// passes through the queue entry and then the output register when the sequencer is
// free. A column above wrap_column moves the glyph to column 0 of the next page,
// with page 7 going to page 0. Codes below 32 render blank columns.
`default_nettype none

module glyph_to_oled_page_bytes_core #(
   parameter int GLYPH_WIDTH = 6,
   parameter int GLYPH_COUNT = 96
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  gop_pkg::req_type          req,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output gop_pkg::rsp_type          rsp,
   input  wire                       csr_wr_en,
   input  wire [gop_pkg::COL_W-1:0]  csr_wr_data
);
   import gop_pkg::*;

   queue_stat_type q_stat;
   desc_type       push_desc;
   desc_type       head;
   logic           push;
   logic           pop;

   gop_front #(
      .GLYPH_COUNT(GLYPH_COUNT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req         (req),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_stat      (q_stat),
      .push        (push),
      .desc        (push_desc)
   );

   gop_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   gop_back #(
      .GLYPH_WIDTH(GLYPH_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_stat    (q_stat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

endmodule

`default_nettype wire

// ===== rtl/core/gop_checker.sv =====
// Port-level checker for the glyph renderer and its bind to the top level.
`default_nettype none

module gop_checker #(
   parameter int GLYPH_WIDTH = 6
) (
   input wire              clock,
   input wire              reset,
   input wire              rsp_valid,
   input wire              rsp_stall,
   input gop_pkg::rsp_type rsp
);
   import gop_pkg::*;

   localparam int            CW        = $clog2(GLYPH_WIDTH + 3);
   localparam logic [CW-1:0] LAST_STEP = CW'(GLYPH_WIDTH + 2);

   logic [CW-1:0] pos_ff;
   logic [CW-1:0] pos_in;
   logic          taken;

   assign taken  = rsp_valid && !rsp_stall;
   assign pos_in = !taken ? pos_ff : ((pos_ff == LAST_STEP) ? '0 : pos_ff + CW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("response dropped or changed while stalled");

   a_page_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && pos_ff == CW'(STEP_PAGE) |-> rsp.out_byte[7:3] == 5'b10110)
      else $error("first byte of a glyph is not a page select");

   a_col_hi_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && pos_ff == CW'(STEP_COL_HI) |-> rsp.out_byte[7:3] == 5'b00010)
      else $error("second byte of a glyph is not a high column command");

   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.is_data == (pos_ff >= CW'(STEP_DATA)))
      else $error("command/data tag out of order");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.last == (pos_ff == LAST_STEP))
      else $error("last flag not on the final glyph byte");

endmodule

bind glyph_to_oled_page_bytes_core gop_checker #(
   .GLYPH_WIDTH(GLYPH_WIDTH)
) u_gop_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

`default_nettype wire
